// ----- rtl/u8v_pkg.sv -----
// shared types and constants of the utf-8 string validator
package u8v_pkg;

	localparam logic [7:0] CTRL_LIMIT   = 8'h20;
	localparam logic [7:0] ASCII_LIMIT  = 8'h80;
	localparam logic [7:0] LEAD2_MASK   = 8'hE0;
	localparam logic [7:0] LEAD2_CODE   = 8'hC0;
	localparam logic [7:0] LEAD2_MIN    = 8'hC2;
	localparam logic [7:0] LEAD3_MASK   = 8'hF0;
	localparam logic [7:0] LEAD3_CODE   = 8'hE0;
	localparam logic [7:0] LEAD3_SURR   = 8'hED;
	localparam logic [7:0] LEAD4_MASK   = 8'hF8;
	localparam logic [7:0] LEAD4_CODE   = 8'hF0;
	localparam logic [7:0] LEAD4_MAX    = 8'hF4;
	localparam logic [7:0] CONT_MASK    = 8'hC0;
	localparam logic [7:0] CONT_CODE    = 8'h80;
	localparam logic [7:0] CONT_A0      = 8'hA0;
	localparam logic [7:0] CONT_90      = 8'h90;

	typedef enum logic [2:0] {
		RULE_NONE  = 3'd0,
		RULE_GE_A0 = 3'd1,
		RULE_LT_A0 = 3'd2,
		RULE_GE_90 = 3'd3,
		RULE_LT_90 = 3'd4
	} rule_t;

	typedef struct packed {
		logic [1:0] pending;
		rule_t      rule;
		logic       error;
	} scan_state_t;

endpackage

// ----- rtl/u8v_if.sv -----
// request and result channels of the utf-8 string validator

interface u8v_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_value;
	logic       string_end;

	modport source (output valid, output byte_value, output string_end, input ready);
	modport sink (input valid, input byte_value, input string_end, output ready);
endinterface

interface u8v_verdict_if;
	logic valid;
	logic ready;
	logic string_valid;

	modport source (output valid, output string_valid, input ready);
	modport sink (input valid, input string_valid, output ready);
endinterface

// ----- rtl/u8v_step.sv -----
// next-state decode for one string byte
module u8v_step (
	input  u8v_pkg::scan_state_t cur,
	input  logic [7:0]           byte_value,
	output u8v_pkg::scan_state_t nxt
);

	logic cont_ok;

	always_comb begin
		cont_ok = (byte_value & u8v_pkg::CONT_MASK) == u8v_pkg::CONT_CODE;
		case (cur.rule)
			u8v_pkg::RULE_GE_A0: cont_ok = cont_ok && (byte_value >= u8v_pkg::CONT_A0);
			u8v_pkg::RULE_LT_A0: cont_ok = cont_ok && (byte_value < u8v_pkg::CONT_A0);
			u8v_pkg::RULE_GE_90: cont_ok = cont_ok && (byte_value >= u8v_pkg::CONT_90);
			u8v_pkg::RULE_LT_90: cont_ok = cont_ok && (byte_value < u8v_pkg::CONT_90);
			default: cont_ok = cont_ok;
		endcase
	end

	always_comb begin
		nxt = cur;
		if (cur.pending != 2'd0) begin
			if (cont_ok) begin
				nxt.rule    = u8v_pkg::RULE_NONE;
				nxt.pending = cur.pending - 2'd1;
			end else begin
				nxt.error   = 1'b1;
				nxt.pending = 2'd0;
				nxt.rule    = u8v_pkg::RULE_NONE;
			end
		end else if (byte_value < u8v_pkg::CTRL_LIMIT) begin
			nxt.error   = 1'b1;
			nxt.pending = 2'd0;
			nxt.rule    = u8v_pkg::RULE_NONE;
		end else if (byte_value < u8v_pkg::ASCII_LIMIT) begin
			nxt = cur;
		end else if ((byte_value & u8v_pkg::LEAD2_MASK) == u8v_pkg::LEAD2_CODE) begin
			if (byte_value < u8v_pkg::LEAD2_MIN) begin
				nxt.error   = 1'b1;
				nxt.pending = 2'd0;
				nxt.rule    = u8v_pkg::RULE_NONE;
			end else begin
				nxt.pending = 2'd1;
				nxt.rule    = u8v_pkg::RULE_NONE;
			end
		end else if ((byte_value & u8v_pkg::LEAD3_MASK) == u8v_pkg::LEAD3_CODE) begin
			nxt.pending = 2'd2;
			if (byte_value == u8v_pkg::LEAD3_CODE) begin
				nxt.rule = u8v_pkg::RULE_GE_A0;
			end else if (byte_value == u8v_pkg::LEAD3_SURR) begin
				nxt.rule = u8v_pkg::RULE_LT_A0;
			end else begin
				nxt.rule = u8v_pkg::RULE_NONE;
			end
		end else if (((byte_value & u8v_pkg::LEAD4_MASK) == u8v_pkg::LEAD4_CODE)
				&& (byte_value <= u8v_pkg::LEAD4_MAX)) begin
			nxt.pending = 2'd3;
			if (byte_value == u8v_pkg::LEAD4_CODE) begin
				nxt.rule = u8v_pkg::RULE_GE_90;
			end else if (byte_value == u8v_pkg::LEAD4_MAX) begin
				nxt.rule = u8v_pkg::RULE_LT_90;
			end else begin
				nxt.rule = u8v_pkg::RULE_NONE;
			end
		end else begin
			nxt.error   = 1'b1;
			nxt.pending = 2'd0;
			nxt.rule    = u8v_pkg::RULE_NONE;
		end
	end

endmodule

// ----- rtl/utf8_string_validator_unit.sv -----
// utf-8 string validator top level: input stage, scan state and result register
// a request is registered in the input stage; an end request's result is then registered in the result register
// throughput: one byte or end request per cycle while no end request waits on an untaken result
// an end request waits in the input stage only while an earlier result is not yet taken
// reset: arst_n clears the input stage, the scan state and the result register at once
module utf8_string_validator_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	u8v_byte_if.sink              bytes,
	u8v_verdict_if.source         verdict
);

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 end_s1;
	logic                 advance_s1;
	logic                 out_valid_q;
	logic                 string_valid_q;
	u8v_pkg::scan_state_t state_q;
	u8v_pkg::scan_state_t state_next;

	assign advance_s1    = valid_s1 && (!end_s1 || !out_valid_q || verdict.ready);
	assign bytes.ready   = !valid_s1 || advance_s1;
	assign verdict.valid = out_valid_q;
	assign verdict.string_valid = string_valid_q;

	u8v_step u_step (
		.cur        (state_q),
		.byte_value (byte_s1),
		.nxt        (state_next)
	);

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			byte_s1 <= bytes.byte_value;
			end_s1  <= bytes.string_end;
		end
	end

	// scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance_s1) begin
			if (end_s1) begin
				state_q <= '0;
			end else begin
				state_q <= state_next;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && end_s1) begin
			out_valid_q <= 1'b1;
		end else if (verdict.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && end_s1) begin
			string_valid_q <= !state_q.error && (state_q.pending == 2'd0);
		end
	end

	a_result_from_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(advance_s1 && end_s1))
		else $error("result shown without an end request");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance_s1 && end_s1) |=> (state_q == '0))
		else $error("scan state not cleared after end request");

	a_rule_needs_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.rule != u8v_pkg::RULE_NONE) |-> (state_q.pending != 2'd0))
		else $error("continuation rule set with nothing pending");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!bytes.ready |-> (valid_s1 && end_s1 && out_valid_q && !verdict.ready))
		else $error("request side stalled without a waiting result");

endmodule
